### src/izn_pkg.sv
// Shared constants, types and saturation helper for the Izhikevich neuron update.
package izn_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int SUBSTEPS_DEF = 4;
	localparam int STEP_W       = 19;
	localparam int STEP_RESET   = 65536;

	localparam int K004_INT = ((4 << FRAC_BITS) + 50) / 100;
	localparam int K004_W   = $clog2(K004_INT + 1) + 1;
	localparam logic signed [K004_W-1:0] K004 = K004_W'(K004_INT);
	localparam logic signed [31:0] K140 = 32'(140 << FRAC_BITS);
	localparam logic signed [31:0] K30  = 32'(30 << FRAC_BITS);

	// product widths inside a substep cell
	localparam int VV_W  = 64;
	localparam int SQ_W  = VV_W - FRAC_BITS;
	localparam int QP_W  = SQ_W + K004_W;
	localparam int SUM_W = QP_W - FRAC_BITS + 3;
	localparam int BV_W  = 18 + 32;
	localparam int DIF_W = BV_W - FRAC_BITS + 1;
	localparam int DU_W  = DIF_W + 18;
	localparam int XH_W  = 32 + STEP_W + 1;

	typedef struct packed {
		logic signed [31:0] v;
		logic signed [31:0] u;
		logic signed [31:0] cur;
		logic        [16:0] a;
		logic signed [17:0] b;
		logic signed [23:0] c;
		logic        [20:0] d;
	} izn_nrn_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return x[31:0];
		end
	endfunction

endpackage

### src/izn_cell.sv
// One forward-Euler substep as a five-stage pipelined cell.
module izn_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic        [izn_pkg::STEP_W-1:0] h,
	input  logic                             vld_i,
	input  izn_pkg::izn_nrn_t                nrn_i,
	output logic                             vld_o,
	output izn_pkg::izn_nrn_t                nrn_o
);

	localparam int F = izn_pkg::FRAC_BITS;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	izn_pkg::izn_nrn_t nrn_s1, nrn_s2, nrn_s3, nrn_s4, nrn_s5;

	logic signed [izn_pkg::VV_W-1:0]  p_vv_s1;
	logic signed [izn_pkg::BV_W-1:0]  p_bv_s1;
	logic signed [izn_pkg::QP_W-1:0]  p_q_s2;
	logic signed [izn_pkg::DU_W-1:0]  p_du_s2;
	logic signed [31:0]               dv_s3, du_s3;
	logic signed [izn_pkg::XH_W-1:0]  p_dvh_s4, p_duh_s4;

	logic signed [izn_pkg::SQ_W-1:0]  sq2;
	logic signed [izn_pkg::DIF_W-1:0] dif2;
	logic signed [izn_pkg::SUM_W-1:0] vx3, sum3;
	logic signed [izn_pkg::STEP_W:0]  hs;

	always_comb begin
		sq2  = signed'(p_vv_s1[izn_pkg::VV_W-1:F]);
		dif2 = izn_pkg::DIF_W'(signed'(p_bv_s1[izn_pkg::BV_W-1:F]))
			- izn_pkg::DIF_W'(nrn_s1.u);
		vx3  = izn_pkg::SUM_W'(nrn_s2.v);
		sum3 = izn_pkg::SUM_W'(signed'(p_q_s2[izn_pkg::QP_W-1:F]))
			+ (vx3 <<< 2) + vx3
			+ izn_pkg::SUM_W'(izn_pkg::K140)
			- izn_pkg::SUM_W'(nrn_s2.u)
			+ izn_pkg::SUM_W'(nrn_s2.cur);
		hs   = signed'({1'b0, h});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// squares and b*v
			nrn_s1  <= nrn_i;
			p_vv_s1 <= nrn_i.v * nrn_i.v;
			p_bv_s1 <= nrn_i.b * nrn_i.v;
			// 0.04*v^2 and a*(b*v - u)
			nrn_s2  <= nrn_s1;
			p_q_s2  <= sq2 * izn_pkg::K004;
			p_du_s2 <= signed'({1'b0, nrn_s1.a}) * dif2;
			// derivatives
			nrn_s3  <= nrn_s2;
			dv_s3   <= izn_pkg::sat32(64'(sum3));
			du_s3   <= izn_pkg::sat32(64'(signed'(p_du_s2[izn_pkg::DU_W-1:F])));
			// scale by h
			nrn_s4   <= nrn_s3;
			p_dvh_s4 <= dv_s3 * hs;
			p_duh_s4 <= du_s3 * hs;
			// integrate
			nrn_s5.v   <= izn_pkg::sat32(64'(nrn_s4.v)
				+ 64'(signed'(p_dvh_s4[izn_pkg::XH_W-1:F])));
			nrn_s5.u   <= izn_pkg::sat32(64'(nrn_s4.u)
				+ 64'(signed'(p_duh_s4[izn_pkg::XH_W-1:F])));
			nrn_s5.cur <= nrn_s4.cur;
			nrn_s5.a   <= nrn_s4.a;
			nrn_s5.b   <= nrn_s4.b;
			nrn_s5.c   <= nrn_s4.c;
			nrn_s5.d   <= nrn_s4.d;
		end
	end

	assign vld_o = vld_s5;
	assign nrn_o = nrn_s5;

endmodule

### src/izn_out.sv
// Spike test and reset, followed by an output register with a skid slot.
module izn_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_i,
	input  izn_pkg::izn_nrn_t nrn_i,
	output logic              up_ready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       m_tdata,
	output logic [0:0]        m_tuser
);

	typedef struct packed {
		logic signed [31:0] v;
		logic signed [31:0] u;
		logic               spk;
	} izn_res_t;

	izn_res_t res, out_q, skid_q;
	logic     out_vld_q, skid_vld_q, up_fire, take;

	always_comb begin
		res.spk = (nrn_i.v >= izn_pkg::K30);
		res.v   = res.spk ? 32'(nrn_i.c) : nrn_i.v;
		res.u   = res.spk ? izn_pkg::sat32(64'(nrn_i.u) + 64'(signed'({1'b0, nrn_i.d})))
			: nrn_i.u;
	end

	assign up_ready = !skid_vld_q;
	assign up_fire  = vld_i && up_ready;
	assign take     = m_tready || !out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q  <= skid_vld_q || up_fire;
			skid_vld_q <= 1'b0;
		end else if (up_fire) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (up_fire) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_q.u, out_q.v};
	assign m_tuser  = out_q.spk;

endmodule

### src/izhikevich_neuron_update.sv
// Izhikevich neuron update: a row of substep cells, spike stage and output buffer.
//
// One neuron per beat. The s_ side takes v, u, I and a, b, c, d; the m_ side
// returns the updated v and u with a spike flag. Exactly one result per beat.
// Each of SUBSTEPS cells runs one Euler substep of size step/SUBSTEPS in five
// pipeline stages (square, scale, derivative, times h, integrate) and hands
// its neuron to the next cell every cycle while s_tready is high.
// From accept to m_tvalid a beat passes the stages of every cell, then the
// output register. Throughput: one beat per cycle while s_tready is high,
// set by the cell pipeline, which has no feedback path.
// cfg_we/cfg_data load the time step; the substep size is derived at the
// write, so write only while no beat is in flight.
// Reset clears all valid bits and sets the step to 1.0 ms.
// When m_tready is low the result holds; one more beat lands in a skid slot,
// then s_tready drops and the whole row of cells freezes until it drains.
module izhikevich_neuron_update #(
	parameter int SUBSTEPS = izn_pkg::SUBSTEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [izn_pkg::STEP_W-1:0]  cfg_data,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// potential, recovery, syn_current, param_a, param_b, param_c, param_d
	input  logic [175:0]                s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// new_potential, new_recovery
	output logic [63:0]                 m_tdata,
	// spiked
	output logic [0:0]                  m_tuser
);

	localparam int SW     = izn_pkg::STEP_W;
	localparam int LG     = $clog2(SUBSTEPS);
	localparam int KSH    = SW + LG;
	localparam int RW     = SW + 2;
	localparam int PROD_W = KSH + SW;
	localparam logic [RW-1:0] RECIP =
		RW'(((64'd1 << KSH) + 64'(SUBSTEPS) - 64'd1) / 64'(SUBSTEPS));
	localparam logic [SW-1:0] H_RESET = SW'(izn_pkg::STEP_RESET / SUBSTEPS);

	logic [SW-1:0]     h_q;
	logic [PROD_W-1:0] h_prod;
	logic              en;

	logic              vld_l [SUBSTEPS+1];
	izn_pkg::izn_nrn_t nrn_l [SUBSTEPS+1];

	assign h_prod = PROD_W'(cfg_data) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= H_RESET;
		end else if (cfg_we) begin
			h_q <= h_prod[KSH +: SW];
		end
	end

	assign s_tready = en;

	assign vld_l[0]     = s_tvalid;
	assign nrn_l[0].v   = s_tdata[31:0];
	assign nrn_l[0].u   = s_tdata[63:32];
	assign nrn_l[0].cur = s_tdata[95:64];
	assign nrn_l[0].a   = s_tdata[112:96];
	assign nrn_l[0].b   = s_tdata[130:113];
	assign nrn_l[0].c   = s_tdata[154:131];
	assign nrn_l[0].d   = s_tdata[175:155];

	for (genvar i = 0; i < SUBSTEPS; i++) begin : g_cell
		izn_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.h      (h_q),
			.vld_i  (vld_l[i]),
			.nrn_i  (nrn_l[i]),
			.vld_o  (vld_l[i+1]),
			.nrn_o  (nrn_l[i+1])
		);
	end

	izn_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_i    (vld_l[SUBSTEPS]),
		.nrn_i    (nrn_l[SUBSTEPS]),
		.up_ready (en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("skid slot full while output register empty");

	a_no_spike_below: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (signed'(m_tdata[31:0]) < izn_pkg::K30))
		else $error("potential at threshold without spike");

	a_step_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> $stable(h_q))
		else $error("substep size changed without a write");

endmodule
